### sv/mstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstg_pkg
// Shared constants, types and step functions of the gradient texel generator.
// ----------------------------------------------------------------------------
package mstg_pkg;

  localparam int MAX_STOPS = 8;
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = 4;
  localparam int TEX_SIZE  = 64;
  localparam int COORD_W   = 6;
  localparam int AX_W      = COORD_W + 2;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int LP_W      = 24;
  localparam int POS_W     = 16;
  localparam int CH_W      = 8;
  localparam int NCH       = 4;
  localparam int T_ONE     = 32768;
  localparam int T_HALF    = 16384;
  localparam int STEPS     = 4;
  localparam int MIN_SEG   = 33;
  localparam int LIN_MIN_A = T_ONE / 500;
  // squared distance at which radial t reaches one
  localparam int SAT_D     = 4096;
  localparam int CFG_AW    = 4;

  localparam logic [1:0] REG_STOP_COUNT = 2'd0;
  localparam logic [1:0] REG_RADIAL     = 2'd1;
  localparam logic [1:0] REG_DIR_X      = 2'd2;
  localparam logic [1:0] REG_DIR_Y      = 2'd3;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef logic [NCH-1:0][CH_W-1:0] rgba_t;

  typedef struct packed {
    logic              smp;
    logic [SLOT_W-1:0] idx;
    logic [POS_W-1:0]  pos;
    rgba_t             col;
  } ld_t;

  typedef struct packed {
    logic [18:0] rem;
    logic [31:0] rad;
    logic [15:0] root;
  } sq_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] num;
    logic [15:0] quo;
  } dv_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  num;
    logic [7:0]  quo;
  } bd_t;

  function automatic sq_t sq_iter(sq_t s);
    sq_t         r;
    logic [18:0] cur;
    logic [18:0] trial;
    r = s;
    for (int k = 0; k < STEPS; k++) begin
      cur   = {r.rem[16:0], r.rad[31:30]};
      trial = {1'b0, r.root, 2'b01};
      if (cur >= trial) begin
        r.rem  = cur - trial;
        r.root = {r.root[14:0], 1'b1};
      end else begin
        r.rem  = cur;
        r.root = {r.root[14:0], 1'b0};
      end
      r.rad = {r.rad[29:0], 2'b00};
    end
    return r;
  endfunction

  function automatic dv_t dv_iter(dv_t s, logic [16:0] den);
    dv_t         r;
    logic [17:0] cur;
    r = s;
    for (int k = 0; k < STEPS; k++) begin
      cur = {r.rem, r.num[15]};
      if (cur >= {1'b0, den}) begin
        r.rem = 17'(cur - {1'b0, den});
        r.quo = {r.quo[14:0], 1'b1};
      end else begin
        r.rem = cur[16:0];
        r.quo = {r.quo[14:0], 1'b0};
      end
      r.num = {r.num[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic bd_t bd_iter(bd_t s, logic [15:0] den);
    bd_t         r;
    logic [16:0] cur;
    r = s;
    for (int k = 0; k < STEPS; k++) begin
      cur = {r.rem, r.num[7]};
      if (cur >= {1'b0, den}) begin
        r.rem = 16'(cur - {1'b0, den});
        r.quo = {r.quo[6:0], 1'b1};
      end else begin
        r.rem = cur[15:0];
        r.quo = {r.quo[6:0], 1'b0};
      end
      r.num = {r.num[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### sv/mstg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstg_in_if / mstg_out_if
// Valid/ready channels carrying input items and texel results.
// ----------------------------------------------------------------------------
interface mstg_in_if;
  import mstg_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [SLOT_W-1:0]  stop_index;
  logic [POS_W-1:0]   stop_position;
  logic [CH_W-1:0]    stop_red;
  logic [CH_W-1:0]    stop_green;
  logic [CH_W-1:0]    stop_blue;
  logic [CH_W-1:0]    stop_alpha;
  logic [COORD_W-1:0] texel_x;
  logic [COORD_W-1:0] texel_y;
  modport source (output valid, func, stop_index, stop_position, stop_red, stop_green,
                  stop_blue, stop_alpha, texel_x, texel_y, input ready);
  modport sink (input valid, func, stop_index, stop_position, stop_red, stop_green,
                stop_blue, stop_alpha, texel_x, texel_y, output ready);
endinterface

interface mstg_out_if;
  import mstg_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

### sv/multi_stop_gradient_texel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stop_gradient_texel_top
// Gradient texel generator: color stop table, t computation, interpolation.
// ----------------------------------------------------------------------------
// in_ch carries load beats (func 0, write one color stop) and sample beats
// (func 1, one texel coordinate). each sample beat yields one RGBA8 beat on
// out_ch; load beats yield nothing. the APB port sets stop count, radial mode
// and the linear direction; the user must see that they are written while
// the block is idle; the block does not enforce this. throughput: one beat
// per cycle while out_ch does not stall. t is formed by the 16-step square
// root / divider unit (four stages of four steps), and the 8-step per-channel
// blend divider has two stages. stop loads take effect in stream order at the
// table stage. reset clears all valid bits and the configuration registers;
// the stop table holds no reset value and must be loaded before it is used.
// when out_ch stalls, the whole pipeline holds and in_ch.ready drops in the
// same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module multi_stop_gradient_texel_top (
  input  logic                          clk,
  input  logic                          rst_n,
  mstg_in_if.sink                       in_ch,
  mstg_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mstg_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import mstg_pkg::*;

  // configuration
  logic [CNT_W-1:0]  stop_count_r;
  logic              radial_r;
  logic [15:0]       dir_x_r;
  logic [15:0]       dir_y_r;
  logic              cfg_wr;
  logic signed [16:0] dxe, dye, dx_abs, dy_abs;
  logic [16:0]       a_cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      radial_r     <= 1'b0;
      dir_x_r      <= '0;
      dir_y_r      <= 16'h8000;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_STOP_COUNT: stop_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_RADIAL:     radial_r     <= cfg_pwdata[0];
        REG_DIR_X:      dir_x_r      <= cfg_pwdata[15:0];
        REG_DIR_Y:      dir_y_r      <= cfg_pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_STOP_COUNT: cfg_prdata = {{(32-CNT_W){1'b0}}, stop_count_r};
      REG_RADIAL:     cfg_prdata = {31'b0, radial_r};
      REG_DIR_X:      cfg_prdata = {{16{dir_x_r[15]}}, dir_x_r};
      REG_DIR_Y:      cfg_prdata = {{16{dir_y_r[15]}}, dir_y_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign dxe    = {dir_x_r[15], dir_x_r};
  assign dye    = {dir_y_r[15], dir_y_r};
  assign dx_abs = dxe[16] ? -dxe : dxe;
  assign dy_abs = dye[16] ? -dye : dye;
  assign a_cfg  = 17'(dx_abs) + 17'(dy_abs);

  // pipeline control
  logic        adv;
  logic [11:0] v_r;
  logic        out_valid_r;
  rgba_t       out_col_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[10:0], in_ch.valid};
      out_valid_r <= v_r[11] && smp12_r;
    end
  end

  // stage 1: capture
  ld_t                ld_r [1:8];
  logic [COORD_W-1:0] tx1_r, ty1_r;
  ld_t                ld1_nxt;

  always_comb begin
    ld1_nxt.smp = (in_ch.func == FUNC_SAMPLE);
    ld1_nxt.idx = in_ch.stop_index;
    ld1_nxt.pos = in_ch.stop_position;
    ld1_nxt.col = {in_ch.stop_alpha, in_ch.stop_blue, in_ch.stop_green, in_ch.stop_red};
  end

  // stage 2: centred coordinates and products
  logic signed [AX_W-1:0] ax, ay;
  logic signed [15:0]     axx, ayy;
  logic [SQ_W-1:0]        sxx2_r, syy2_r;
  logic signed [LP_W-1:0] pxx_nxt, pyy_nxt, pxx2_r, pyy2_r;

  assign ax      = $signed({1'b0, tx1_r, 1'b1}) - $signed(AX_W'(TEX_SIZE));
  assign ay      = $signed({1'b0, ty1_r, 1'b1}) - $signed(AX_W'(TEX_SIZE));
  assign axx     = ax * ax;
  assign ayy     = ay * ay;
  assign pxx_nxt = ax * $signed(dir_x_r);
  assign pyy_nxt = ay * $signed(dir_y_r);

  // stage 3: sums and iteration start
  logic [SQ_W:0]          dsum;
  logic signed [LP_W:0]   psum, pabs;
  sq_t                    sq3_nxt;
  dv_t                    dv3_nxt;
  logic [29:0]            nlin;
  sq_t                    sq_r  [0:4];
  dv_t                    dv_r  [0:4];
  logic                   sat_r [0:4];
  logic                   neg_r [0:4];

  assign dsum = {1'b0, sxx2_r} + {1'b0, syy2_r};
  assign psum = {pxx2_r[LP_W-1], pxx2_r} + {pyy2_r[LP_W-1], pyy2_r};
  assign pabs = psum[LP_W] ? -psum : psum;
  assign nlin = {pabs[21:0], 8'b0};

  always_comb begin
    sq3_nxt.rem  = '0;
    sq3_nxt.rad  = {2'b0, dsum[11:0], 18'b0};
    sq3_nxt.root = '0;
    dv3_nxt.rem  = {3'b0, nlin[29:16]};
    dv3_nxt.num  = nlin[15:0];
    dv3_nxt.quo  = '0;
  end

  // stage 8: gradient parameter
  logic [POS_W-1:0]   t8_nxt, t8_r;
  logic [17:0]        qmag;
  logic signed [17:0] qs, tl;

  always_comb begin
    qmag = {2'b0, dv_r[4].quo} + 18'(dv_r[4].rem != '0);
    qs   = neg_r[4] ? -$signed(qmag) : $signed({2'b0, dv_r[4].quo});
    tl   = $signed(18'(T_HALF)) + qs;
    if (radial_r) begin
      t8_nxt = sat_r[4] ? POS_W'(T_ONE) : sq_r[4].root;
    end else if (a_cfg <= 17'(LIN_MIN_A)) begin
      t8_nxt = POS_W'(T_HALF);
    end else if (tl < 0) begin
      t8_nxt = '0;
    end else if (tl > $signed(18'(T_ONE))) begin
      t8_nxt = POS_W'(T_ONE);
    end else begin
      t8_nxt = tl[POS_W-1:0];
    end
  end

  // stage 9: stop table, segment search
  logic [POS_W-1:0]  pos_mem [MAX_STOPS];
  rgba_t             col_mem [MAX_STOPS];
  logic [CNT_W-1:0]  n_use;
  logic [SLOT_W-1:0] last_i, sel_a, sel_b, seg_i;
  logic              seg_any, seg_sel, zero_sel;
  logic              smp9_r, seg9_r;
  rgba_t             c0_9_r, c1_9_r;
  logic [POS_W-1:0]  p0_9_r, p1_9_r, t9_r;

  always_comb begin
    n_use   = (stop_count_r > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count_r;
    last_i  = SLOT_W'(n_use - 1'b1);
    seg_any = 1'b0;
    seg_i   = '0;
    for (int i = MAX_STOPS - 2; i >= 0; i--) begin
      if ((CNT_W'(i + 1) < n_use) && (t8_r >= pos_mem[i]) && (t8_r <= pos_mem[i+1])) begin
        seg_any = 1'b1;
        seg_i   = SLOT_W'(i);
      end
    end
    sel_a    = '0;
    seg_sel  = 1'b0;
    zero_sel = 1'b0;
    if (n_use == '0) begin
      zero_sel = 1'b1;
    end else if ((t8_r <= pos_mem[0]) || (n_use == CNT_W'(1))) begin
      sel_a = '0;
    end else if (t8_r >= pos_mem[last_i]) begin
      sel_a = last_i;
    end else if (seg_any) begin
      sel_a   = seg_i;
      seg_sel = 1'b1;
    end else begin
      sel_a = last_i;
    end
    sel_b = seg_sel ? SLOT_W'(sel_a + 1'b1) : sel_a;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_r[7] && !ld_r[8].smp) begin
        pos_mem[ld_r[8].idx] <= ld_r[8].pos;
        col_mem[ld_r[8].idx] <= ld_r[8].col;
      end
      c0_9_r <= zero_sel ? '0 : col_mem[sel_a];
      c1_9_r <= col_mem[sel_b];
      p0_9_r <= pos_mem[sel_a];
      p1_9_r <= pos_mem[sel_b];
      seg9_r <= seg_sel && !zero_sel;
      smp9_r <= ld_r[8].smp;
      t9_r   <= t8_r;
    end
  end

  // stage 10: blend products
  logic [POS_W-1:0]    range9, range10_r, range11_r;
  logic [POS_W:0]      num9;
  logic                blend9, blend10_r, blend11_r, blend12_r;
  logic                smp10_r, smp11_r, smp12_r;
  rgba_t               c0_10_r, c0_11_r, c0_12_r;
  logic signed [8:0]   diff [NCH];
  logic signed [25:0]  prod [NCH];
  logic [NCH-1:0]      bneg10_r, bneg11_r, bneg12_r;
  logic [23:0]         babs10_r [NCH];
  bd_t                 bd11_r [NCH];
  bd_t                 bd12_r [NCH];
  bd_t                 bd_init [NCH];

  assign range9 = p1_9_r - p0_9_r;
  assign num9   = {1'b0, t9_r} - {1'b0, p0_9_r};
  assign blend9 = seg9_r && (range9 >= POS_W'(MIN_SEG));

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      diff[c] = $signed({1'b0, c1_9_r[c]}) - $signed({1'b0, c0_9_r[c]});
      prod[c] = diff[c] * $signed(num9);
      bd_init[c].rem = babs10_r[c][23:8];
      bd_init[c].num = babs10_r[c][7:0];
      bd_init[c].quo = '0;
    end
  end

  // output channel values
  rgba_t              out_nxt;
  logic signed [9:0]  vmag, vq, vsum;

  always_comb begin
    out_nxt = c0_12_r;
    vmag    = '0;
    vq      = '0;
    vsum    = '0;
    for (int c = 0; c < NCH; c++) begin
      vmag = {2'b0, bd12_r[c].quo} + 10'(bd12_r[c].rem != '0);
      vq   = bneg12_r[c] ? -vmag : $signed({2'b0, bd12_r[c].quo});
      vsum = $signed({2'b0, c0_12_r[c]}) + vq;
      if (blend12_r) begin
        if (vsum < 0) begin
          out_nxt[c] = '0;
        end else if (vsum > 10'sd255) begin
          out_nxt[c] = '1;
        end else begin
          out_nxt[c] = vsum[7:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      ld_r[1] <= ld1_nxt;
      tx1_r   <= in_ch.texel_x;
      ty1_r   <= in_ch.texel_y;

      ld_r[2] <= ld_r[1];
      sxx2_r  <= axx[SQ_W-1:0];
      syy2_r  <= ayy[SQ_W-1:0];
      pxx2_r  <= pxx_nxt;
      pyy2_r  <= pyy_nxt;

      ld_r[3]  <= ld_r[2];
      sq_r[0]  <= sq3_nxt;
      dv_r[0]  <= dv3_nxt;
      sat_r[0] <= (dsum >= (SQ_W+1)'(SAT_D));
      neg_r[0] <= psum[LP_W];

      for (int k = 1; k <= 4; k++) begin
        ld_r[k+3] <= ld_r[k+2];
        sq_r[k]   <= sq_iter(sq_r[k-1]);
        dv_r[k]   <= dv_iter(dv_r[k-1], a_cfg);
        sat_r[k]  <= sat_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end

      ld_r[8] <= ld_r[7];
      t8_r    <= t8_nxt;

      smp10_r   <= smp9_r;
      blend10_r <= blend9;
      c0_10_r   <= c0_9_r;
      range10_r <= range9;
      for (int c = 0; c < NCH; c++) begin
        bneg10_r[c] <= prod[c][25];
        babs10_r[c] <= prod[c][25] ? 24'(-prod[c]) : prod[c][23:0];
        bd11_r[c]   <= bd_iter(bd_init[c], range10_r);
        bd12_r[c]   <= bd_iter(bd11_r[c], range11_r);
      end

      smp11_r   <= smp10_r;
      blend11_r <= blend10_r;
      c0_11_r   <= c0_10_r;
      range11_r <= range10_r;
      bneg11_r  <= bneg10_r;

      smp12_r   <= smp11_r;
      blend12_r <= blend11_r;
      c0_12_r   <= c0_11_r;
      bneg12_r  <= bneg11_r;

      if (v_r[11] && smp12_r) begin
        out_col_r <= out_nxt;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_col_r[0];
  assign out_ch.out_green = out_col_r[1];
  assign out_ch.out_blue  = out_col_r[2];
  assign out_ch.out_alpha = out_col_r[3];

endmodule

### sv/mstg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstg_checker
// Port-level checks of the gradient texel generator, bound to the top level.
// ----------------------------------------------------------------------------
module mstg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_beat
);
  import mstg_pkg::*;

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not follow output side");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_beat))
    else $error("result beat changed while stalled");

endmodule

bind multi_stop_gradient_texel_top mstg_checker u_mstg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_beat  ({out_ch.out_alpha, out_ch.out_blue, out_ch.out_green, out_ch.out_red})
);
